>>> src/sfhf_pkg.sv
// Package for the stance-foot height fusion block.
// Holds sizes, register and command codes, controller states, the
// controller/datapath command and status structs, and a saturation helper.
package sfhf_pkg;

  localparam int unsigned MaxContacts = 4;
  localparam int unsigned SlotW = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;
  localparam int unsigned SumW = 36;
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic signed [51:0] HalfQ16 = 52'sd32768;

  typedef enum logic [1:0] {
    MODE_FILTER = 2'd0,
    MODE_KIN    = 2'd1,
    MODE_BLEND  = 2'd2,
    MODE_ANCHOR = 2'd3
  } height_mode_e;

  typedef enum logic [1:0] {
    CFG_HEIGHT_MODE = 2'd0,
    CFG_GROUND_Z    = 2'd1,
    CFG_ANCHOR_THR  = 2'd2,
    CFG_KIN_WEIGHT  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_SEED   = 1'b0,
    CMD_SAMPLE = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_ANCHOR,
    ST_ACCUM,
    ST_PREP,
    ST_DIV,
    ST_SIGN,
    ST_MUL_FILT,
    ST_MUL_KIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic anchor_upd;
    logic accum;
    logic slot_adv;
    logic frame_end;
    logic div_start;
    logic div_step;
    logic kin_load;
    logic no_kin;
    logic mul_filt;
    logic mul_kin;
    logic round;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sample;
    logic last;
    logic mode_active;
    logic mode_kin_only;
    logic count_nz;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // Clamps a signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic [32:0] hi;
    logic signed [31:0] r;
    hi = v[63:31];
    if ((&hi) || (~|hi)) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

>>> src/sfhf_if.sv
// Valid/ready channel interfaces for the stance-foot height fusion block.
// Does not depend on sfhf_pkg; the payloads use fixed widths.
interface sfhf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] filter_height;
  logic signed [31:0] relative_height;
  logic               stance;
  logic               last_contact;

  modport source (output valid, command, filter_height, relative_height, stance,
                  last_contact, input ready);
  modport sink (input valid, command, filter_height, relative_height, stance,
                last_contact, output ready);
endinterface

interface sfhf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fused_height;
  logic signed [31:0] kin_height;
  logic               kinematic_valid;

  modport source (output valid, fused_height, kin_height, kinematic_valid,
                  input ready);
  modport sink (input valid, fused_height, kin_height, kinematic_valid,
                output ready);
endinterface

>>> src/sfhf_ctrl.sv
// Controller state machine of the stance-foot height fusion block.
// Sequences capture, anchor update, accumulation, division, blend and output
// through command and status structs from sfhf_pkg.
module sfhf_ctrl import sfhf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_MEAS;
        end
      end
      ST_MEAS: begin
        state_d = ST_ANCHOR;
      end
      ST_ANCHOR: begin
        cmd_o.anchor_upd = 1'b1;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (!status_i.last) begin
          cmd_o.slot_adv = 1'b1;
          state_d = ST_IDLE;
        end else if (!status_i.sample) begin
          cmd_o.frame_end = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.mode_active && status_i.count_nz) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.no_kin = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd_o.kin_load = 1'b1;
        state_d = status_i.mode_kin_only ? ST_OUT : ST_MUL_FILT;
      end
      ST_MUL_FILT: begin
        cmd_o.mul_filt = 1'b1;
        state_d = ST_MUL_KIN;
      end
      ST_MUL_KIN: begin
        cmd_o.mul_kin = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.frame_end = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The divider only runs for the last sample of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (status_i.sample && status_i.last))
    else $error("divider running outside a last sample");

  // A blend always follows a completed division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_FILT) |-> ($past(state_q) == ST_SIGN))
    else $error("blend entered without a quotient");

endmodule

>>> src/sfhf_dp.sv
// Datapath of the stance-foot height fusion block: configuration registers,
// per-contact anchors and stance history, height sum, serial divider and
// blend multiplier. Driven by sfhf_ctrl through the structs in sfhf_pkg.
module sfhf_dp import sfhf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_command_i,
  input  logic signed [31:0] in_filter_height_i,
  input  logic signed [31:0] in_relative_height_i,
  input  logic               in_support_i,
  input  logic               in_last_contact_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_fused_height_o,
  output logic signed [31:0] out_kin_height_o,
  output logic               out_kinematic_valid_o,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o
);

  height_mode_e       mode_q;
  logic signed [31:0] ground_z_q;
  logic [30:0]        thr_q;
  logic [16:0]        kin_weight_q;

  logic signed [31:0] anchor_q [MaxContacts];
  logic               was_stance_q [MaxContacts];
  logic [SlotW-1:0]   slot_q;
  logic signed [SumW-1:0] sum_q;
  logic [CountW-1:0]  count_q;

  command_e           cmd_q;
  logic signed [31:0] fh_q;
  logic signed [31:0] rh_q;
  logic               stance_q;
  logic               last_q;

  logic signed [32:0] measured_q;
  logic signed [33:0] diff_q;

  logic [DivCntW-1:0] div_cnt_q;
  logic [SumW-1:0]    quo_q;
  logic [CountW-1:0]  rem_q;
  logic               neg_q;

  logic signed [31:0] kin_q;
  logic               kin_valid_q;
  logic signed [31:0] rep_q;
  logic signed [49:0] prod_f_q;
  logic signed [49:0] prod_k_q;

  logic               out_valid_q;
  logic signed [31:0] out_rep_q;
  logic signed [31:0] out_kin_q;
  logic               out_kv_q;

  logic signed [31:0] slot_anchor;
  logic [33:0]        diff_abs;
  logic               re_anchor;
  logic               sample;
  logic               mode_active;
  logic               add_stance;
  logic signed [31:0] ground_sel;
  logic signed [37:0] sum_wide;
  logic signed [SumW-1:0] sum_sat;
  logic [SumW-1:0]    sum_mag;
  logic [CountW:0]    trial;
  logic               trial_ge;
  logic signed [SumW:0] quo_ext;
  logic signed [SumW:0] quo_s;
  logic [16:0]        w_sat;
  logic [16:0]        w_filt;
  logic signed [51:0] rnd_sum;
  logic signed [51:0] rnd_shift;

  assign slot_anchor = anchor_q[slot_q];
  assign sample      = (cmd_q == CMD_SAMPLE);
  assign mode_active = (mode_q != MODE_FILTER);
  assign diff_abs    = diff_q[33] ? 34'(-diff_q) : 34'(diff_q);
  assign re_anchor   = (mode_q == MODE_ANCHOR) && stance_q && !was_stance_q[slot_q]
                       && (diff_abs > {3'b000, thr_q});
  assign add_stance  = sample && mode_active && stance_q && (count_q != CountMax);
  assign ground_sel  = (mode_q == MODE_ANCHOR) ? slot_anchor : ground_z_q;
  assign sum_wide    = 38'(sum_q) + 38'(ground_sel) - 38'(rh_q);

  always_comb begin
    if ((&sum_wide[37:SumW-1]) || (~|sum_wide[37:SumW-1])) begin
      sum_sat = sum_wide[SumW-1:0];
    end else if (sum_wide[37]) begin
      sum_sat = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SumW-1){1'b1}}};
    end
  end

  assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign trial    = {rem_q, quo_q[SumW-1]};
  assign trial_ge = (trial >= {1'b0, count_q});
  assign quo_ext  = $signed({1'b0, quo_q});
  assign quo_s    = neg_q ? -quo_ext : quo_ext;

  assign w_sat     = (kin_weight_q > OneQ16) ? OneQ16 : kin_weight_q;
  assign w_filt    = OneQ16 - w_sat;
  assign rnd_sum   = 52'(prod_f_q) + 52'(prod_k_q) + HalfQ16;
  assign rnd_shift = rnd_sum >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FILTER;
      ground_z_q   <= '0;
      thr_q        <= '0;
      kin_weight_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEIGHT_MODE: mode_q       <= height_mode_e'(cfg_data_i[1:0]);
        CFG_GROUND_Z:    ground_z_q   <= cfg_data_i;
        CFG_ANCHOR_THR:  thr_q        <= cfg_data_i[30:0];
        CFG_KIN_WEIGHT:  kin_weight_q <= cfg_data_i[16:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxContacts; i++) begin
        anchor_q[i]     <= '0;
        was_stance_q[i] <= 1'b0;
      end
      slot_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.anchor_upd) begin
        if (!sample) begin
          anchor_q[slot_q]     <= rh_q;
          was_stance_q[slot_q] <= 1'b0;
        end else if (mode_active) begin
          if (re_anchor) begin
            anchor_q[slot_q] <= sat32(64'(measured_q));
          end
          was_stance_q[slot_q] <= stance_q;
        end
      end
      if (cmd_i.accum && add_stance) begin
        sum_q   <= sum_sat;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.slot_adv) begin
        slot_q <= (slot_q == SlotW'(MaxContacts - 1)) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.frame_end) begin
        slot_q  <= '0;
        sum_q   <= '0;
        count_q <= '0;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_e'(in_command_i);
      fh_q     <= in_filter_height_i;
      rh_q     <= in_relative_height_i;
      stance_q <= in_support_i;
      last_q   <= in_last_contact_i;
    end
    measured_q <= 33'(fh_q) + 33'(rh_q);
    diff_q     <= 34'(fh_q) + 34'(rh_q) - 34'(slot_anchor);
    if (cmd_i.div_start) begin
      quo_q <= sum_mag;
      rem_q <= '0;
      neg_q <= sum_q[SumW-1];
    end else if (cmd_i.div_step) begin
      if (trial_ge) begin
        rem_q <= CountW'(trial - {1'b0, count_q});
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= trial[CountW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
    if (cmd_i.no_kin) begin
      kin_q       <= '0;
      kin_valid_q <= 1'b0;
      rep_q       <= fh_q;
    end
    if (cmd_i.kin_load) begin
      kin_q       <= sat32(64'(quo_s));
      kin_valid_q <= 1'b1;
      rep_q       <= sat32(64'(quo_s));
    end
    if (cmd_i.mul_filt) begin
      prod_f_q <= $signed({1'b0, w_filt}) * fh_q;
    end
    if (cmd_i.mul_kin) begin
      prod_k_q <= $signed({1'b0, w_sat}) * kin_q;
    end
    if (cmd_i.round) begin
      rep_q <= sat32(64'(rnd_shift));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rep_q <= rep_q;
      out_kin_q <= kin_q;
      out_kv_q  <= kin_valid_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_fused_height_o    = out_rep_q;
  assign out_kin_height_o      = out_kin_q;
  assign out_kinematic_valid_o = out_kv_q;

  assign status_o.sample        = sample;
  assign status_o.last          = last_q;
  assign status_o.mode_active   = mode_active;
  assign status_o.mode_kin_only = (mode_q == MODE_KIN);
  assign status_o.count_nz      = (count_q != '0);
  assign status_o.div_done      = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign status_o.out_free      = !out_valid_q || out_ready_i;

  // The partial remainder stays below the stance count during division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < count_q))
    else $error("divider remainder out of range");

  // An invalid kinematic result always carries a zero height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_kv_q) |-> (out_kin_q == '0))
    else $error("invalid kinematic height is not zero");

  // A valid kinematic result is never produced in filter-only mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && kin_valid_q) |-> (mode_q != MODE_FILTER))
    else $error("kinematic result in filter-only mode");

endmodule

>>> src/stance_foot_height_fusion.sv
// Top level of the stance-foot height fusion block.
// A seed or a non-final sample passes the measure, anchor and accumulate states before
// the next acceptance. A final sample with no stance or in filter mode goes to output;
// kinematic mode adds the 36-step serial divider, blend modes also the multiplier.
// A finished item waits in an output register while the next item is accepted.
// Asynchronous active-low reset clears configuration, anchors, stance history and sums.
module stance_foot_height_fusion import sfhf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  sfhf_in_if.sink     in_i,
  sfhf_out_if.source  out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  sfhf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfhf_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_command_i          (in_i.command),
    .in_filter_height_i    (in_i.filter_height),
    .in_relative_height_i  (in_i.relative_height),
    .in_support_i          (in_i.stance),
    .in_last_contact_i     (in_i.last_contact),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_fused_height_o    (out_o.fused_height),
    .out_kin_height_o      (out_o.kin_height),
    .out_kinematic_valid_o (out_o.kinematic_valid),
    .cmd_i                 (cmd),
    .status_o              (status)
  );

endmodule

>>> tb/stance_foot_height_fusion_test.sv
`timescale 1ns / 1ps
// Self-checking regression for stance_foot_height_fusion: directed frames, then random
// frames under several register settings and idle patterns, checked against a tracker.
// Depends on sfhf_pkg, the sfhf_in_if/sfhf_out_if interfaces and the block itself.
module stance_foot_height_fusion_test import sfhf_pkg::*;;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned ItemsPerPhase = 50;
  localparam logic signed [31:0] HeightMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] HeightMin = 32'sh8000_0000;
  localparam longint SumMax = (64'sd1 <<< (SumW - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  typedef struct {
    command_e           command;
    logic signed [31:0] filter_height;
    logic signed [31:0] relative_height;
    logic               stance;
    logic               last_contact;
  } contact_t;

  typedef struct {
    logic signed [31:0] fused_height;
    logic signed [31:0] kin_height;
    logic               kinematic_valid;
  } height_t;

  class height_fusion_tracker;
    height_mode_e       mode;
    logic signed [31:0] ground_z;
    logic [30:0]        anchor_thr;
    logic [16:0]        kin_weight;
    logic signed [31:0] anchor [MaxContacts];
    logic               was_stance [MaxContacts];
    longint             sum;
    int unsigned        count;
    int unsigned        slot;
    height_t            expected_heights [$];
    int unsigned        mismatches;

    function new();
      mode = MODE_FILTER;
      ground_z = '0;
      anchor_thr = '0;
      kin_weight = '0;
      for (int i = 0; i < MaxContacts; i++) begin
        anchor[i] = '0;
        was_stance[i] = 1'b0;
      end
      mismatches = 0;
      end_frame();
    endfunction

    function void end_frame();
      slot = 0;
      sum = 0;
      count = 0;
    endfunction

    function void advance_slot();
      slot = (slot + 1 >= MaxContacts) ? 0 : slot + 1;
    endfunction

    function logic signed [31:0] clamp_height(longint v);
      if (v > 64'sd2147483647) return HeightMax;
      if (v < -64'sd2147483648) return HeightMin;
      return v[31:0];
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_HEIGHT_MODE: mode = height_mode_e'(data[1:0]);
        CFG_GROUND_Z:    ground_z = data;
        CFG_ANCHOR_THR:  anchor_thr = data[30:0];
        CFG_KIN_WEIGHT:  kin_weight = data[16:0];
        default: ;
      endcase
    endfunction

    function void note_contact(contact_t c);
      longint fh, rh, measured, diff, g, w, acc, kin, reported;
      logic valid;
      int unsigned s;
      height_t r;
      fh = c.filter_height;
      rh = c.relative_height;
      s = slot;
      if (c.command == CMD_SEED) begin
        anchor[s] = c.relative_height;
        was_stance[s] = 1'b0;
        if (c.last_contact) end_frame();
        else advance_slot();
        return;
      end
      if (mode != MODE_FILTER) begin
        if (mode == MODE_ANCHOR && c.stance && !was_stance[s]) begin
          measured = fh + rh;
          diff = measured - longint'(anchor[s]);
          if (diff < 0) diff = -diff;
          if (diff > longint'(anchor_thr)) anchor[s] = clamp_height(measured);
        end
        was_stance[s] = c.stance;
        if (c.stance && count < CountMax) begin
          if (mode == MODE_ANCHOR) g = anchor[s];
          else g = ground_z;
          sum = sum + g - rh;
          if (sum > SumMax) sum = SumMax;
          if (sum < SumMin) sum = SumMin;
          count++;
        end
      end
      if (!c.last_contact) begin
        advance_slot();
        return;
      end
      reported = fh;
      kin = 0;
      valid = 1'b0;
      if (mode != MODE_FILTER && count != 0) begin
        kin = clamp_height(sum / longint'(count));
        valid = 1'b1;
        if (mode == MODE_KIN) begin
          reported = kin;
        end else begin
          if (kin_weight > OneQ16) w = 65536;
          else w = kin_weight;
          acc = (65536 - w) * fh + w * kin;
          reported = clamp_height((acc + 32768) >>> 16);
        end
      end
      end_frame();
      r.fused_height = reported[31:0];
      r.kin_height = kin[31:0];
      r.kinematic_valid = valid;
      expected_heights.insert(expected_heights.size(), r);
    endfunction

    function void check_height(height_t got);
      height_t want;
      if (expected_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: reported %0d kinematic %0d valid %0b",
                   got.fused_height, got.kin_height, got.kinematic_valid);
        return;
      end
      want = expected_heights.pop_front();
      if (want.fused_height !== got.fused_height ||
          want.kin_height !== got.kin_height ||
          want.kinematic_valid !== got.kinematic_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected reported %0d kinematic %0d valid %0b, got %0d %0d %0b",
                   want.fused_height, want.kin_height, want.kinematic_valid,
                   got.fused_height, got.kin_height, got.kinematic_valid);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned cycle_count;
  height_t     seen;
  height_fusion_tracker tracker;

  sfhf_in_if  in_ch ();
  sfhf_out_if out_ch ();

  stance_foot_height_fusion dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.fused_height = out_ch.fused_height;
      seen.kin_height = out_ch.kin_height;
      seen.kinematic_valid = out_ch.kinematic_valid;
      tracker.check_height(seen);
    end
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stance_foot_height_fusion regression: fail");
    $finish;
  end

  function automatic contact_t contact(command_e cmd, logic signed [31:0] fh,
                                       logic signed [31:0] rh, logic stance, logic last);
    contact_t c;
    c.command = cmd;
    c.filter_height = fh;
    c.relative_height = rh;
    c.stance = stance;
    c.last_contact = last;
    return c;
  endfunction

  function automatic logic signed [31:0] pick_height(logic signed [31:0] nominal,
                                                      int unsigned extreme_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < extreme_pct) begin
      case ($urandom_range(0, 3))
        0: return HeightMin;
        1: return HeightMax;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r < extreme_pct + 10) return $urandom();
    return nominal + int'($urandom_range(0, 8192)) - 4096;
  endfunction

  task automatic send_contact(contact_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c.command;
    in_ch.filter_height <= c.filter_height;
    in_ch.relative_height <= c.relative_height;
    in_ch.stance <= c.stance;
    in_ch.last_contact <= c.last_contact;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_contact(c);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_settings(height_mode_e m, logic [31:0] gz, logic [31:0] thr,
                                logic [31:0] w);
    logic [31:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? $urandom() : 32'd0;
    write_reg(CFG_HEIGHT_MODE, {junk[31:2], m});
    write_reg(CFG_GROUND_Z, gz);
    write_reg(CFG_ANCHOR_THR, thr);
    write_reg(CFG_KIN_WEIGHT, w | {junk[31:17], 17'd0});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.expected_heights.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_frame(int unsigned len, int unsigned stance_pct, int unsigned extreme_pct,
                            logic signed [31:0] base, logic signed [31:0] ground);
    contact_t c;
    for (int unsigned i = 0; i < len; i++) begin
      c.command = ($urandom_range(0, 99) < 8) ? CMD_SEED : CMD_SAMPLE;
      c.filter_height = pick_height(base, extreme_pct);
      c.relative_height = pick_height((c.command == CMD_SEED) ? ground : ground - base,
                                      extreme_pct);
      c.stance = ($urandom_range(0, 99) < stance_pct);
      c.last_contact = (i == len - 1);
      send_contact(c);
    end
  endtask

  task automatic run_directed();
    apply_settings(MODE_FILTER, 32'd0, 32'd0, 32'd0);
    send_contact(contact(CMD_SAMPLE, HeightMax, HeightMin, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, HeightMin, HeightMax, 1'b1, 1'b1));
    drain();
    apply_settings(MODE_KIN, HeightMax, 32'd0, 32'd0);
    send_contact(contact(CMD_SEED, 0, HeightMin, 1'b0, 1'b0));
    send_contact(contact(CMD_SAMPLE, 5, HeightMin, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, 5, HeightMin, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, 5, 0, 1'b0, 1'b0));
    send_contact(contact(CMD_SAMPLE, 5, HeightMin, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, -7, HeightMin, 1'b1, 1'b1));
    send_contact(contact(CMD_SAMPLE, 9, 3, 1'b0, 1'b1));
    send_contact(contact(CMD_SEED, 1, 2, 1'b1, 1'b1));
    drain();
    apply_settings(MODE_ANCHOR, 32'd0, 32'h7fff_ffff, 32'h0001_ffff);
    send_contact(contact(CMD_SEED, 0, 100, 1'b0, 1'b0));
    send_contact(contact(CMD_SEED, 0, HeightMin, 1'b0, 1'b0));
    send_contact(contact(CMD_SAMPLE, HeightMax, HeightMax, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, 0, -50, 1'b1, 1'b1));
    send_contact(contact(CMD_SAMPLE, HeightMin, HeightMin, 1'b1, 1'b0));
    send_contact(contact(CMD_SAMPLE, 0, 0, 1'b1, 1'b1));
    drain();
    apply_settings(MODE_BLEND, 32'd0, 32'd0, 32'd32768);
    send_contact(contact(CMD_SAMPLE, 2, -1, 1'b1, 1'b1));
    send_contact(contact(CMD_SAMPLE, -3, 0, 1'b1, 1'b1));
    send_contact(contact(CMD_SAMPLE, 1000, 4, 1'b0, 1'b0));
    send_contact(contact(CMD_SAMPLE, -20, -10, 1'b1, 1'b1));
    drain();
  endtask

  task automatic run_random_phase(int unsigned p);
    int unsigned sel, sent, kind, len;
    logic signed [31:0] base, ground;
    logic [31:0] gz, thr, w;
    height_mode_e m;
    case ((p * 3) / RandomPhases)
      0: begin
        src_idle_pct = 15;
        snk_idle_pct = 47;
      end
      1: begin
        src_idle_pct = 47;
        snk_idle_pct = 15;
      end
      default: begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
    endcase
    base = int'($urandom_range(0, 8388608)) - 4194304;
    ground = int'($urandom_range(0, 131072)) - 65536;
    sel = (p < 5) ? p : $urandom_range(0, 4);
    if (p < 4) m = height_mode_e'((p + 1) % 4);
    else m = height_mode_e'($urandom_range(0, 3));
    case (sel)
      0: gz = HeightMin;
      1: gz = HeightMax;
      3: gz = $urandom();
      default: gz = ground;
    endcase
    case (sel)
      0: thr = 32'd0;
      1: thr = 32'h7fff_ffff;
      2: thr = 32'hffff_ffff;
      default: thr = $urandom_range(0, 16384);
    endcase
    case (sel)
      0: w = 32'd0;
      1: w = 32'd65536;
      2: w = 32'h0001_ffff;
      3: w = $urandom();
      default: w = $urandom_range(0, 65536);
    endcase
    apply_settings(m, gz, thr, w);
    sent = 0;
    if (p < 2) begin
      for (int unsigned i = 0; i < 36; i++)
        send_contact(contact(CMD_SAMPLE, $urandom(), (p == 0) ? HeightMax : HeightMin,
                             1'b1, i == 35));
      sent = 36;
    end
    while (sent < ItemsPerPhase) begin
      kind = $urandom_range(0, 99);
      if (kind < 2) len = $urandom_range(32, 38);
      else if (kind < 12) len = $urandom_range(5, 7);
      else len = $urandom_range(1, MaxContacts);
      send_frame(len, $urandom_range(30, 95), $urandom_range(0, 8), base, ground);
      sent += len;
    end
    drain();
  endtask

  initial begin
    tracker = new();
    src_idle_pct = 15;
    snk_idle_pct = 47;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_HEIGHT_MODE;
    cfg_data <= 32'd0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_SAMPLE;
    in_ch.filter_height <= 32'sd0;
    in_ch.relative_height <= 32'sd0;
    in_ch.stance <= 1'b0;
    in_ch.last_contact <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int unsigned p = 0; p < RandomPhases; p++) run_random_phase(p);
    if (tracker.mismatches == 0 && tracker.expected_heights.size() == 0) begin
      $display("stance_foot_height_fusion regression: pass");
    end else begin
      $display("stance_foot_height_fusion regression: fail");
    end
    $finish;
  end

endmodule
